FILE: src/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared constants and helpers for the great-circle distance core
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 22;

  localparam logic [15:0] RADIUS_RESET = 16'd6371;

  // pi with 60 fraction bits
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  localparam logic [28:0] DEG_TO_RAD_Q34 = 29'((((PI_Q60 >> 25) / 180) + 64'd1) >> 1);
  localparam logic [30:0] HALF_PI_Q30    = 31'(((PI_Q60 >> 30) + 64'd1) >> 1);
  localparam logic [30:0] ONE_Q30        = 31'h4000_0000;

  localparam int SIN_TERMS  = 7;
  localparam int ASIN_BITS  = 30;

  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 40;
  localparam int DIST_W      = 34;

  // taylor divisor of term n: (2n)(2n+1)
  function automatic int sin_div(int n);
    return (2 * n) * (2 * n + 1);
  endfunction

endpackage

FILE: src/gcd_sin.sv
// ----------------------------------------------------------------------------
// gcd_sin
// Pipelined Q30 sine by Taylor series, one term per three stages
// ----------------------------------------------------------------------------
module gcd_sin #(
  parameter int TagW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic [30:0]     x_i,
  input  logic [TagW-1:0] tag_i,
  output logic            vld_o,
  output logic [30:0]     sin_o,
  output logic [TagW-1:0] tag_o
);

  localparam int NTerm = gcd_pkg::SIN_TERMS;

  logic [NTerm:0]        vld_s;
  logic [31:0]           term_s [NTerm+1];
  logic [31:0]           x2_s   [NTerm+1];
  logic signed [34:0]    sum_s  [NTerm+1];
  logic [TagW-1:0]       tag_s  [NTerm+1];

  logic [61:0]     sq_q;
  logic [30:0]     x0_q;
  logic            v0_q;
  logic [TagW-1:0] tag0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q   <= 62'(x_i) * 62'(x_i);
      x0_q   <= x_i;
      tag0_q <= tag_i;
    end
  end

  assign vld_s[0]  = v0_q;
  assign term_s[0] = {1'b0, x0_q};
  assign x2_s[0]   = sq_q[61:30];
  assign sum_s[0]  = signed'({4'd0, x0_q});
  assign tag_s[0]  = tag0_q;

  for (genvar n = 1; n <= NTerm; n++) begin : g_term
    localparam int          Div   = gcd_pkg::sin_div(n);
    localparam logic [31:0] Recip = 32'((64'd1 << 32) / Div);
    localparam bit          Neg   = (n % 2) == 1;

    logic [63:0]        prod_q;
    logic [63:0]        qe_q;
    logic [31:0]        v_q;
    logic [31:0]        x2a_q, x2b_q;
    logic signed [34:0] suma_q, sumb_q, sumc_q;
    logic [TagW-1:0]    taga_q, tagb_q, tagc_q;
    logic               va_q, vb_q, vc_q;
    logic [31:0]        term_q;
    logic [31:0]        q0, q1, rem;
    logic [39:0]        back;

    always_comb begin
      q0   = qe_q[63:32];
      back = 40'(q0) * 40'(Div);
      rem  = v_q - back[31:0];
      q1   = (rem >= 32'(Div)) ? q0 + 32'd1 : q0;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        va_q <= 1'b0;
        vb_q <= 1'b0;
        vc_q <= 1'b0;
      end else if (en_i) begin
        va_q <= vld_s[n-1];
        vb_q <= va_q;
        vc_q <= vb_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        prod_q <= 64'(term_s[n-1]) * 64'(x2_s[n-1]);
        x2a_q  <= x2_s[n-1];
        suma_q <= sum_s[n-1];
        taga_q <= tag_s[n-1];
        qe_q   <= 64'(prod_q[61:30]) * 64'(Recip);
        v_q    <= prod_q[61:30];
        x2b_q  <= x2a_q;
        sumb_q <= suma_q;
        tagb_q <= taga_q;
        term_q <= q1;
        sumc_q <= Neg ? sumb_q - signed'({3'd0, q1}) : sumb_q + signed'({3'd0, q1});
        tagc_q <= tagb_q;
      end
    end

    logic [31:0] x2c_q;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x2c_q <= x2b_q;
      end
    end

    assign vld_s[n]  = vc_q;
    assign term_s[n] = term_q;
    assign x2_s[n]   = x2c_q;
    assign sum_s[n]  = sumc_q;
    assign tag_s[n]  = tagc_q;
  end

  logic [30:0]     sin_d, sin_q;
  logic            vo_q;
  logic [TagW-1:0] tago_q;

  always_comb begin
    if (sum_s[NTerm] < 35'sd0) begin
      sin_d = '0;
    end else if (sum_s[NTerm] > 35'sd1073741824) begin
      sin_d = gcd_pkg::ONE_Q30;
    end else begin
      sin_d = sum_s[NTerm][30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= vld_s[NTerm];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q  <= sin_d;
      tago_q <= tag_s[NTerm];
    end
  end

  assign vld_o = vo_q;
  assign sin_o = sin_q;
  assign tag_o = tago_q;

endmodule

FILE: src/gcd_front.sv
// ----------------------------------------------------------------------------
// gcd_front
// Angle preparation, four sines and the haversine term a
// ----------------------------------------------------------------------------
module gcd_front #(
  parameter int ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic signed [29:0] lat1_i,
  input  logic signed [30:0] lon1_i,
  input  logic signed [29:0] lat2_i,
  input  logic signed [30:0] lon2_i,
  output logic               vld_o,
  output logic [30:0]        a_o
);

  localparam logic signed [29:0] LatLim   = 30'(90 * (2 ** ANGLE_FRAC_BITS));
  localparam logic signed [30:0] LonLim   = 31'(180 * (2 ** ANGLE_FRAC_BITS));
  localparam logic [30:0]        Right    = 31'(90 * (2 ** (ANGLE_FRAC_BITS + 1)));
  localparam logic [30:0]        Straight = 31'(180 * (2 ** (ANGLE_FRAC_BITS + 1)));
  localparam int                 Sh       = ANGLE_FRAC_BITS + 5;
  localparam logic [60:0]        Rnd      = 61'(1) << (Sh - 1);

  logic [4:0] vf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= '0;
    end else if (en_i) begin
      vf_q <= {vf_q[3:0], vld_i};
    end
  end

  // clamp
  logic signed [29:0] lat1_q, lat2_q;
  logic signed [30:0] lon1_q, lon2_q;

  function automatic logic signed [29:0] clamp_lat(logic signed [29:0] v);
    if (v > LatLim) begin
      return LatLim;
    end else if (v < -LatLim) begin
      return -LatLim;
    end
    return v;
  endfunction

  function automatic logic signed [30:0] clamp_lon(logic signed [30:0] v);
    if (v > LonLim) begin
      return LonLim;
    end else if (v < -LonLim) begin
      return -LonLim;
    end
    return v;
  endfunction

  // differences and magnitudes
  logic signed [30:0] dlat_s;
  logic signed [31:0] dlon_s;
  logic [29:0]        dlat_q;
  logic [30:0]        dlon_q;
  logic [28:0]        alat1_q, alat2_q;

  assign dlat_s = $signed({lat2_q[29], lat2_q}) - $signed({lat1_q[29], lat1_q});
  assign dlon_s = $signed({lon2_q[30], lon2_q}) - $signed({lon1_q[30], lon1_q});

  // half angle differences and co-latitudes in degrees, one extra fraction bit
  logic [30:0] deg_q [4];
  logic [59:0] rad_prod_q [4];
  logic [30:0] x_q [4];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lat1_q  <= clamp_lat(lat1_i);
      lat2_q  <= clamp_lat(lat2_i);
      lon1_q  <= clamp_lon(lon1_i);
      lon2_q  <= clamp_lon(lon2_i);
      dlat_q  <= dlat_s[30] ? 30'(-dlat_s) : dlat_s[29:0];
      dlon_q  <= dlon_s[31] ? 31'(-dlon_s) : dlon_s[30:0];
      alat1_q <= lat1_q[29] ? 29'(-lat1_q) : lat1_q[28:0];
      alat2_q <= lat2_q[29] ? 29'(-lat2_q) : lat2_q[28:0];
      deg_q[0] <= {1'b0, dlat_q};
      deg_q[1] <= (dlon_q > Right) ? Straight - dlon_q : dlon_q;
      deg_q[2] <= Right - {1'b0, alat1_q, 1'b0};
      deg_q[3] <= Right - {1'b0, alat2_q, 1'b0};
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_rad
    logic [60:0] rnd_sum;
    assign rnd_sum = 61'(rad_prod_q[i]) + Rnd;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_prod_q[i] <= 60'(deg_q[i]) * 60'(gcd_pkg::DEG_TO_RAD_Q34);
        x_q[i]        <= 31'(rnd_sum >> Sh);
      end
    end
  end

  // sines: lat half, lon half, cos lat1, cos lat2
  logic [30:0] sn [4];
  logic        sv;

  gcd_sin #(.TagW(1)) u_sin_lat (
    .clk_i, .rst_ni, .en_i,
    .vld_i(vf_q[4]), .x_i(x_q[0]), .tag_i(1'b0),
    .vld_o(sv), .sin_o(sn[0]), .tag_o()
  );

  for (genvar i = 1; i < 4; i++) begin : g_sin
    gcd_sin #(.TagW(1)) u_sin (
      .clk_i, .rst_ni, .en_i,
      .vld_i(vf_q[4]), .x_i(x_q[i]), .tag_i(1'b0),
      .vld_o(), .sin_o(sn[i]), .tag_o()
    );
  end

  // combine
  logic [2:0]  vc_q;
  logic [61:0] sl2_q, kk_q, so2_q, ks_q;
  logic [30:0] sl_q;
  logic [30:0] a_q;
  logic [31:0] a_sum;

  assign a_sum = {1'b0, sl_q} + 32'(ks_q[61:30]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= '0;
    end else if (en_i) begin
      vc_q <= {vc_q[1:0], sv};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sl2_q <= 62'(sn[0]) * 62'(sn[0]);
      so2_q <= 62'(sn[1]) * 62'(sn[1]);
      kk_q  <= 62'(sn[2]) * 62'(sn[3]);
      sl_q  <= sl2_q[60:30];
      ks_q  <= 62'(kk_q[60:30]) * 62'(so2_q[60:30]);
      a_q   <= (a_sum > 32'(gcd_pkg::ONE_Q30)) ? gcd_pkg::ONE_Q30 : a_sum[30:0];
    end
  end

  assign vld_o = vc_q[2];
  assign a_o   = a_q;

endmodule

FILE: src/gcd_sqrt.sv
// ----------------------------------------------------------------------------
// gcd_sqrt
// Two-lane pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module gcd_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  logic [30:0] a_i,
  output logic        vld_o,
  output logic [30:0] p_o,
  output logic [30:0] q_o
);

  localparam int NStep = 31;

  logic [NStep:0] vld_s;
  logic [61:0]    rem_s  [2][NStep+1];
  logic [61:0]    root_s [2][NStep+1];

  logic        v0_q;
  logic [61:0] r0p_q, r0q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r0p_q <= {1'b0, a_i, 30'd0};
      r0q_q <= {1'b0, 31'(gcd_pkg::ONE_Q30 - a_i), 30'd0};
    end
  end

  assign vld_s[0]     = v0_q;
  assign rem_s[0][0]  = r0p_q;
  assign rem_s[1][0]  = r0q_q;
  assign root_s[0][0] = '0;
  assign root_s[1][0] = '0;

  for (genvar k = 0; k < NStep; k++) begin : g_step
    localparam int          Pos = 2 * (NStep - 1 - k);
    localparam logic [61:0] Bit = 62'(1) << Pos;

    logic vq;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vq <= 1'b0;
      end else if (en_i) begin
        vq <= vld_s[k];
      end
    end
    assign vld_s[k+1] = vq;

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [61:0] trial;
      logic [61:0] rem_q, root_q;
      assign trial = root_s[l][k] + Bit;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (rem_s[l][k] >= trial) begin
            rem_q  <= rem_s[l][k] - trial;
            root_q <= (root_s[l][k] >> 1) + Bit;
          end else begin
            rem_q  <= rem_s[l][k];
            root_q <= root_s[l][k] >> 1;
          end
        end
      end
      assign rem_s[l][k+1]  = rem_q;
      assign root_s[l][k+1] = root_q;
    end
  end

  assign vld_o = vld_s[NStep];
  assign p_o   = root_s[0][NStep][30:0];
  assign q_o   = root_s[1][NStep][30:0];

endmodule

FILE: src/gcd_asin.sv
// ----------------------------------------------------------------------------
// gcd_asin
// Arcsine by bitwise search over pipelined sine stages
// ----------------------------------------------------------------------------
module gcd_asin (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  logic [30:0] p_i,
  input  logic [30:0] q_i,
  output logic        vld_o,
  output logic [30:0] theta_o
);

  localparam int NB   = gcd_pkg::ASIN_BITS;
  localparam int TagW = 1 + 31 + NB;

  logic [NB:0]   vld_s;
  logic [NB-1:0] t_s   [NB+1];
  logic [30:0]   y_s   [NB+1];
  logic [NB:0]   sel_s;

  logic        v0_q, sel0_q;
  logic [30:0] y0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sel0_q <= p_i > q_i;
      y0_q   <= (p_i > q_i) ? q_i : p_i;
    end
  end

  assign vld_s[0] = v0_q;
  assign t_s[0]   = '0;
  assign y_s[0]   = y0_q;
  assign sel_s[0] = sel0_q;

  for (genvar k = 0; k < NB; k++) begin : g_bit
    localparam logic [NB-1:0] Mask = NB'(1) << (NB - 1 - k);

    logic [NB-1:0]   cand;
    logic            sv;
    logic [30:0]     sn;
    logic [TagW-1:0] tag_out;
    logic [NB-1:0]   t_o, c_o;
    logic [30:0]     y_o;
    logic            vq, sel_q;
    logic [NB-1:0]   t_q;
    logic [30:0]     y_q;

    assign cand = t_s[k] | Mask;

    gcd_sin #(.TagW(TagW)) u_sin (
      .clk_i, .rst_ni, .en_i,
      .vld_i(vld_s[k]), .x_i({1'b0, cand}),
      .tag_i({sel_s[k], y_s[k], t_s[k]}),
      .vld_o(sv), .sin_o(sn), .tag_o(tag_out)
    );

    assign t_o = tag_out[NB-1:0];
    assign y_o = tag_out[NB+30:NB];
    assign c_o = t_o | Mask;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vq <= 1'b0;
      end else if (en_i) begin
        vq <= sv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t_q   <= (sn <= y_o) ? c_o : t_o;
        y_q   <= y_o;
        sel_q <= tag_out[TagW-1];
      end
    end

    assign vld_s[k+1] = vq;
    assign t_s[k+1]   = t_q;
    assign y_s[k+1]   = y_q;
    assign sel_s[k+1] = sel_q;
  end

  logic        vo_q;
  logic [30:0] theta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= vld_s[NB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      theta_q <= sel_s[NB] ? gcd_pkg::HALF_PI_Q30 - {1'b0, t_s[NB]} : {1'b0, t_s[NB]};
    end
  end

  assign vld_o   = vo_q;
  assign theta_o = theta_q;

endmodule

FILE: src/great_circle_distance_core.sv
// ----------------------------------------------------------------------------
// great_circle_distance_core
// Haversine great-circle distance between two points, scaled by a radius
// ----------------------------------------------------------------------------
// channel  direction  beat contents
// s_axis   in         tdata: first_latitude, first_longitude, second_latitude,
//                     second_longitude
// m_axis   out        tdata: arc_distance
// cfg      in         data: sphere_radius
//
// one beat per cycle in each direction while the output is not stalled; the
// thirty sine stages of the arcsine search make up most of the pipeline
// reset clears all valid bits and loads the radius 6371
// a stalled output holds the pipeline; the skid stage takes the beat in flight
// ----------------------------------------------------------------------------
module great_circle_distance_core #(
  parameter int ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // first_latitude, first_longitude, second_latitude, second_longitude, pad
  input  logic [gcd_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // arc_distance, pad
  output logic [gcd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [15:0]                        cfg_data_i
);

  localparam int DW = gcd_pkg::DIST_W;

  logic [15:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= gcd_pkg::RADIUS_RESET;
    end else if (cfg_valid_i) begin
      radius_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  logic skid_vld_q, out_vld_q;
  logic en;

  assign en              = !skid_vld_q;
  assign s_axis_tready_o = en;

  logic signed [29:0] lat1, lat2;
  logic signed [30:0] lon1, lon2;

  assign lat1 = s_axis_tdata_i[29:0];
  assign lon1 = s_axis_tdata_i[60:30];
  assign lat2 = s_axis_tdata_i[90:61];
  assign lon2 = s_axis_tdata_i[121:91];

  logic        a_vld, r_vld, t_vld;
  logic [30:0] a_val, p_val, q_val, theta;

  gcd_front #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(s_axis_tvalid_i),
    .lat1_i(lat1), .lon1_i(lon1), .lat2_i(lat2), .lon2_i(lon2),
    .vld_o(a_vld), .a_o(a_val)
  );

  gcd_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(a_vld), .a_i(a_val),
    .vld_o(r_vld), .p_o(p_val), .q_o(q_val)
  );

  gcd_asin u_asin (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(r_vld), .p_i(p_val), .q_i(q_val),
    .vld_o(t_vld), .theta_o(theta)
  );

  // scale by radius
  logic        prod_vld_q;
  logic [47:0] prod_q;
  logic [48:0] rnd_sum;
  logic [DW-1:0] dist_rnd;

  assign rnd_sum  = {1'b0, prod_q} + 49'(1 << 13);
  assign dist_rnd = rnd_sum[DW+13:14];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else if (en) begin
      prod_vld_q <= t_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= 48'({theta, 1'b0}) * 48'(radius_q);
    end
  end

  // output register and skid
  logic          out_free;
  logic [DW-1:0] out_q, skid_q;

  assign out_free = !out_vld_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_free) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end
    end else if (out_free) begin
      out_vld_q <= prod_vld_q;
    end else if (prod_vld_q) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_free) begin
        out_q <= skid_q;
      end
    end else if (out_free) begin
      out_q <= dist_rnd;
    end else begin
      skid_q <= dist_rnd;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {(gcd_pkg::OUT_TDATA_W - DW)'(0), out_q};

endmodule

FILE: src/gcd_checker.sv
// ----------------------------------------------------------------------------
// gcd_checker
// Port-level checks for the great-circle distance core
// ----------------------------------------------------------------------------
module gcd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [gcd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  // a stalled beat stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output beat dropped under stall");

  // a stalled beat keeps its data
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output data changed under stall");

  // pad bits stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[gcd_pkg::OUT_TDATA_W-1:gcd_pkg::DIST_W] == '0)
    else $error("output pad bits set");

  // input back-pressure only follows an output stall
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> $past(m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without output stall");

endmodule

bind great_circle_distance_core gcd_checker u_gcd_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o(m_axis_tdata_o)
);
